>>> rtl/core/gbs_pkg.sv
// ----------------------------------------------------------------------------
// gbs_pkg
// Shared constants and types for the greedy box suppression unit.
// ----------------------------------------------------------------------------
package gbs_pkg;

    localparam int MAX_KEPT_DEF   = 256;
    localparam int COORD_BITS_DEF = 13;
    localparam int THR_BITS       = 16;
    localparam int POS_BITS       = 16;

    localparam logic [THR_BITS-1:0] THR_RESET = 16'd29491;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AREA,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } gbs_state_t;

    typedef struct packed {
        logic busy;
        logic exceed;
    } overlap_status_t;

endpackage

>>> rtl/core/greedy_box_suppression_unit.sv
// ----------------------------------------------------------------------------
// greedy_box_suppression_unit
// Greedy overlap suppression of score-sorted boxes against the boxes kept so
// far in the frame, with the kept list held in one synchronous memory.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake               Payload
//  in        input      in_valid / in_stall     box_left, box_top, box_width,
//                                               box_height, first_of_frame
//  out       output     out_valid / out_stall   kept, box_position, store_full
//  cfg       input      cfg_wr_en               cfg_wr_data (iou_threshold)
//
//  A box is compared against every stored box in turn: the single memory read
//  port delivers one stored box per cycle into the four-stage overlap test
//  behind it, and the result waits until that test has drained.
//  Reset clears the kept count, the frame position and loads the threshold;
//  the memory needs no clearing pass, since only written entries are read.
//  A waiting result does not block the next input beat; a finished box waits
//  for the output register to free up.
// ----------------------------------------------------------------------------
module greedy_box_suppression_unit #(
    parameter int MAX_KEPT   = gbs_pkg::MAX_KEPT_DEF,
    parameter int COORD_BITS = gbs_pkg::COORD_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [gbs_pkg::THR_BITS-1:0]    cfg_wr_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic signed [COORD_BITS-1:0]    box_left,
    input  logic signed [COORD_BITS-1:0]    box_top,
    input  logic [COORD_BITS-1:0]           box_width,
    input  logic [COORD_BITS-1:0]           box_height,
    input  logic                            first_of_frame,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            kept,
    output logic [gbs_pkg::POS_BITS-1:0]    box_position,
    output logic                            store_full
);
    import gbs_pkg::*;

    localparam int CB    = COORD_BITS;
    localparam int AW    = 2 * CB;
    localparam int ENT_W = 4 * CB + AW;
    localparam int IDX_W = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int CNT_W = $clog2(MAX_KEPT + 1);

    gbs_state_t state_reg, state_next;

    logic [THR_BITS-1:0] thr_reg;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    j_reg, j_next;
    logic [POS_BITS-1:0] fpos_reg, fpos_next;
    logic [POS_BITS-1:0] pos_reg, pos_next;
    logic                drop_reg, drop_next;
    logic                out_valid_reg, out_valid_next;
    logic                kept_reg, store_full_reg;
    logic [POS_BITS-1:0] box_position_reg;

    logic signed [CB-1:0] left_reg, top_reg;
    logic [CB-1:0]        width_reg, height_reg;
    logic [AW-1:0]        area_reg;
    logic [AW-1:0]        area_prod;

    logic                 ld_box, ld_area, rd_en, wr_en, out_load, full;
    logic [ENT_W-1:0]     mem [MAX_KEPT];
    logic [ENT_W-1:0]     rd_data_reg;
    logic                 rd_v_reg;
    overlap_status_t      ov_status;

    assign area_prod = width_reg * height_reg;
    assign full      = (count_reg == CNT_W'(MAX_KEPT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            thr_reg       <= THR_RESET;
            count_reg     <= '0;
            j_reg         <= '0;
            fpos_reg      <= '0;
            pos_reg       <= '0;
            drop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            rd_v_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            j_reg         <= j_next;
            fpos_reg      <= fpos_next;
            pos_reg       <= pos_next;
            drop_reg      <= drop_next;
            out_valid_reg <= out_valid_next;
            rd_v_reg      <= rd_en;
            if (cfg_wr_en)
            begin
                thr_reg <= cfg_wr_data;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        j_next         = j_reg;
        fpos_next      = fpos_reg;
        pos_next       = pos_reg;
        drop_next      = drop_reg | ov_status.exceed;
        out_valid_next = out_valid_reg & out_stall;
        in_stall       = 1'b1;
        ld_box         = 1'b0;
        ld_area        = 1'b0;
        rd_en          = 1'b0;
        wr_en          = 1'b0;
        out_load       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    ld_box = 1'b1;
                    if (first_of_frame)
                    begin
                        count_next = '0;
                        pos_next   = '0;
                    end
                    else
                    begin
                        pos_next = fpos_reg;
                    end
                    fpos_next  = (first_of_frame ? '0 : fpos_reg) + 1'b1;
                    state_next = ST_AREA;
                end
            end
            ST_AREA:
            begin
                ld_area    = 1'b1;
                j_next     = '0;
                drop_next  = 1'b0;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (j_reg != count_reg)
                begin
                    rd_en  = 1'b1;
                    j_next = j_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!rd_v_reg && !ov_status.busy)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    if (!drop_reg && !full)
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ld_box)
        begin
            left_reg   <= box_left;
            top_reg    <= box_top;
            width_reg  <= box_width;
            height_reg <= box_height;
        end
        if (ld_area)
        begin
            area_reg <= area_prod;
        end
        if (out_load)
        begin
            kept_reg         <= !drop_reg;
            store_full_reg   <= !drop_reg && full;
            box_position_reg <= pos_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[IDX_W-1:0]] <= {left_reg, top_reg, width_reg, height_reg, area_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[j_reg[IDX_W-1:0]];
        end
    end

    gbs_overlap_pipe #(
        .COORD_BITS (COORD_BITS)
    ) u_overlap (
        .clk        (clk),
        .rst_n      (rst_n),
        .box_left   (left_reg),
        .box_top    (top_reg),
        .box_width  (width_reg),
        .box_height (height_reg),
        .box_area   (area_reg),
        .threshold  (thr_reg),
        .ent_valid  (rd_v_reg),
        .ent_left   (rd_data_reg[ENT_W-1 -: CB]),
        .ent_top    (rd_data_reg[ENT_W-CB-1 -: CB]),
        .ent_width  (rd_data_reg[ENT_W-2*CB-1 -: CB]),
        .ent_height (rd_data_reg[ENT_W-3*CB-1 -: CB]),
        .ent_area   (rd_data_reg[AW-1:0]),
        .status     (ov_status)
    );

    assign out_valid    = out_valid_reg;
    assign kept         = kept_reg;
    assign store_full   = store_full_reg;
    assign box_position = box_position_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_KEPT))
        else $error("kept count beyond store depth");

    a_read_below_count: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> (j_reg < count_reg))
        else $error("read of an unwritten store entry");

    a_full_implies_kept: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(store_full && !kept))
        else $error("store_full set on a dropped box");

    a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken while a box is in work");

endmodule

>>> rtl/core/gbs_overlap_pipe.sv
// ----------------------------------------------------------------------------
// gbs_overlap_pipe
// Four-stage overlap test of the current box against one stored box per beat.
// ----------------------------------------------------------------------------
module gbs_overlap_pipe #(
    parameter int COORD_BITS = gbs_pkg::COORD_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic signed [COORD_BITS-1:0]        box_left,
    input  logic signed [COORD_BITS-1:0]        box_top,
    input  logic [COORD_BITS-1:0]               box_width,
    input  logic [COORD_BITS-1:0]               box_height,
    input  logic [2*COORD_BITS-1:0]             box_area,
    input  logic [gbs_pkg::THR_BITS-1:0]        threshold,
    input  logic                                ent_valid,
    input  logic signed [COORD_BITS-1:0]        ent_left,
    input  logic signed [COORD_BITS-1:0]        ent_top,
    input  logic [COORD_BITS-1:0]               ent_width,
    input  logic [COORD_BITS-1:0]               ent_height,
    input  logic [2*COORD_BITS-1:0]             ent_area,
    output gbs_pkg::overlap_status_t            status
);
    import gbs_pkg::*;

    localparam int CB   = COORD_BITS;
    localparam int EW   = CB + 2;
    localparam int AW   = 2 * CB;
    localparam int UW   = AW + 1;
    localparam int PW   = UW + THR_BITS;

    logic signed [EW-1:0] a_l, a_t, a_r, a_b;
    logic signed [EW-1:0] b_l, b_t, b_r, b_b;
    logic signed [EW-1:0] x0, y0, x1, y1, dxs, dys;
    logic [CB-1:0]        dx, dy;

    logic          s2_v_reg, s3_v_reg, s4_v_reg, s5_v_reg;
    logic [CB-1:0] s2_dx_reg, s2_dy_reg;
    logic [AW-1:0] s2_area_reg, s3_area_reg;
    logic [AW-1:0] s3_inter_reg, s4_inter_reg, s5_inter_reg;
    logic [UW-1:0] s4_uni_reg;
    logic [PW-1:0] s5_prod_reg;

    always_comb
    begin
        a_l = EW'(box_left);
        a_t = EW'(box_top);
        a_r = a_l + signed'({2'b00, box_width});
        a_b = a_t + signed'({2'b00, box_height});
        b_l = EW'(ent_left);
        b_t = EW'(ent_top);
        b_r = b_l + signed'({2'b00, ent_width});
        b_b = b_t + signed'({2'b00, ent_height});
        x0  = (a_l > b_l) ? a_l : b_l;
        y0  = (a_t > b_t) ? a_t : b_t;
        x1  = (a_r < b_r) ? a_r : b_r;
        y1  = (a_b < b_b) ? a_b : b_b;
        dxs = x1 - x0;
        dys = y1 - y0;
        dx  = (dxs > 0) ? dxs[CB-1:0] : '0;
        dy  = (dys > 0) ? dys[CB-1:0] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
            s5_v_reg <= 1'b0;
        end
        else
        begin
            s2_v_reg <= ent_valid;
            s3_v_reg <= s2_v_reg;
            s4_v_reg <= s3_v_reg;
            s5_v_reg <= s4_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_dx_reg    <= dx;
        s2_dy_reg    <= dy;
        s2_area_reg  <= ent_area;
        s3_inter_reg <= s2_dx_reg * s2_dy_reg;
        s3_area_reg  <= s2_area_reg;
        s4_uni_reg   <= {1'b0, box_area} + {1'b0, s3_area_reg} - {1'b0, s3_inter_reg};
        s4_inter_reg <= s3_inter_reg;
        s5_prod_reg  <= threshold * s4_uni_reg;
        s5_inter_reg <= s4_inter_reg;
    end

    assign status.busy   = s2_v_reg | s3_v_reg | s4_v_reg | s5_v_reg;
    assign status.exceed = s5_v_reg && ({1'b0, s5_inter_reg, {THR_BITS{1'b0}}} > s5_prod_reg);

endmodule
